// File: rtl/rlse_pkg.sv
// Shared types and constants for the single-wire RGB LED serial encoder.
// Holds the request and result payload structs and the register map.
// Depends on nothing; used by rlse_core and rgb_led_serial_encoder.
package rlse_pkg;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic dout;
    logic byte_taken;
    logic sending;
    logic in_latch;
  } result_t;

  typedef struct packed {
    logic [7:0]  period_cycles;
    logic [7:0]  zero_high_cycles;
    logic [7:0]  one_high_cycles;
    logic [15:0] latch_cycles;
  } cfg_t;

  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD    = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_HIGH = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_HIGH  = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LATCH     = 8'd3;

  localparam logic [7:0]  PERIOD_RESET    = 8'd20;
  localparam logic [7:0]  ZERO_HIGH_RESET = 8'd5;
  localparam logic [7:0]  ONE_HIGH_RESET  = 8'd14;
  localparam logic [15:0] LATCH_RESET     = 16'd800;

  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// File: rtl/rgb_led_serial_encoder.sv
// Top level of the single-wire RGB LED serial encoder.
// Holds the configuration registers and the result register around rlse_core.
// Depends on rlse_pkg and rlse_core.
//
//   channel  direction  payload            handshake
//   in       request    rlse_pkg::item_t   in_valid / in_ready
//   out      result     rlse_pkg::result_t out_valid / out_ready
//   cfg      write      cfg_index, cfg_data cfg_valid / cfg_ready
//
// Each request is one tick of the line timing and yields one registered result in the following cycle.
// One request is taken every cycle while the result register is empty or being read.
// The rate is set by the single state update in rlse_core, done once per request.
// A stalled result holds in the result register and blocks further requests.
// Synchronous reset restores the default timing and empties all state.
module rgb_led_serial_encoder #(
  parameter int TIMING_WIDTH = 8,
  parameter int LATCH_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rlse_pkg::item_t                        in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output rlse_pkg::result_t                      out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rlse_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rlse_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  rlse_pkg::cfg_t    cfg;
  rlse_pkg::result_t step_result;
  logic              step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_cycles    <= rlse_pkg::PERIOD_RESET;
      cfg.zero_high_cycles <= rlse_pkg::ZERO_HIGH_RESET;
      cfg.one_high_cycles  <= rlse_pkg::ONE_HIGH_RESET;
      cfg.latch_cycles     <= rlse_pkg::LATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rlse_pkg::REG_PERIOD:    cfg.period_cycles    <= cfg_data[7:0];
        rlse_pkg::REG_ZERO_HIGH: cfg.zero_high_cycles <= cfg_data[7:0];
        rlse_pkg::REG_ONE_HIGH:  cfg.one_high_cycles  <= cfg_data[7:0];
        rlse_pkg::REG_LATCH:     cfg.latch_cycles     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rlse_core #(
    .TIMING_WIDTH(TIMING_WIDTH),
    .LATCH_WIDTH (LATCH_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (in_data),
    .cfg   (cfg),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= step_result;
    end
  end

  // The line is driven high only while a byte is being shifted out.
  a_dout_sending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dout |-> out_data.sending)
    else $error("line high outside a byte");

  // Shifting and the latch period never overlap.
  a_latch_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.sending && out_data.in_latch))
    else $error("latch period during shifting");

  // Every accepted request produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request without result");

  // A byte is only taken when one was offered.
  a_taken_offered: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.byte_valid |=> !out_data.byte_taken)
    else $error("byte taken without offer");

endmodule

// File: rtl/rlse_core.sv
// Bit timing, holding register and shift register of the LED serial encoder.
// Advances one tick per accepted request and returns that tick's line result.
// Depends on rlse_pkg for the payload and configuration types.
module rlse_core #(
  parameter int TIMING_WIDTH = 8,
  parameter int LATCH_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rlse_pkg::item_t   item,
  input  rlse_pkg::cfg_t    cfg,
  output rlse_pkg::result_t result
);

  logic [7:0]              hold_byte, hold_byte_next;
  logic                    hold_full, hold_full_next;
  logic                    hold_last, hold_last_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [2:0]              bit_index, bit_index_next;
  logic [TIMING_WIDTH-1:0] bit_timer, bit_timer_next;
  logic                    active, active_next;
  logic                    cur_last, cur_last_next;
  logic [LATCH_WIDTH-1:0]  latch_timer, latch_timer_next;

  logic [TIMING_WIDTH:0]   timer_inc;
  logic [7:0]              high_cycles;
  logic [LATCH_WIDTH-1:0]  latch_load;
  logic                    taken;

  always_comb begin
    if ((32'(cfg.latch_cycles) >> LATCH_WIDTH) != 32'd0) begin
      latch_load = '1;
    end else begin
      latch_load = LATCH_WIDTH'(cfg.latch_cycles);
    end
  end

  always_comb begin
    hold_byte_next   = hold_byte;
    hold_full_next   = hold_full;
    hold_last_next   = hold_last;
    shift_byte_next  = shift_byte;
    bit_index_next   = bit_index;
    bit_timer_next   = bit_timer;
    active_next      = active;
    cur_last_next    = cur_last;
    latch_timer_next = latch_timer;
    result           = '0;
    taken            = item.byte_valid && !hold_full;
    high_cycles      = shift_byte[7] ? cfg.one_high_cycles : cfg.zero_high_cycles;
    timer_inc        = {1'b0, bit_timer} + {{TIMING_WIDTH{1'b0}}, 1'b1};

    if (active) begin
      result.dout    = 32'(bit_timer) < 32'(high_cycles);
      result.sending = 1'b1;
      if (timer_inc[TIMING_WIDTH] || 32'(timer_inc) >= 32'(cfg.period_cycles)) begin
        bit_timer_next  = '0;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_index_next  = bit_index + 3'd1;
        if (bit_index == rlse_pkg::LAST_BIT) begin
          if (cur_last) begin
            active_next      = 1'b0;
            latch_timer_next = latch_load;
          end else if (hold_full) begin
            shift_byte_next = hold_byte;
            cur_last_next   = hold_last;
            hold_full_next  = 1'b0;
            bit_index_next  = '0;
            bit_timer_next  = '0;
            active_next     = 1'b1;
          end else begin
            active_next = 1'b0;
          end
        end
      end else begin
        bit_timer_next = timer_inc[TIMING_WIDTH-1:0];
      end
    end else if (latch_timer != '0) begin
      result.in_latch  = 1'b1;
      latch_timer_next = latch_timer - {{(LATCH_WIDTH-1){1'b0}}, 1'b1};
    end else if (hold_full) begin
      shift_byte_next = hold_byte;
      cur_last_next   = hold_last;
      hold_full_next  = 1'b0;
      bit_index_next  = '0;
      bit_timer_next  = '0;
      active_next     = 1'b1;
    end

    if (taken) begin
      hold_byte_next = item.byte_value;
      hold_last_next = item.frame_end;
      hold_full_next = 1'b1;
    end
    result.byte_taken = taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_byte   <= '0;
      hold_full   <= 1'b0;
      hold_last   <= 1'b0;
      shift_byte  <= '0;
      bit_index   <= '0;
      bit_timer   <= '0;
      active      <= 1'b0;
      cur_last    <= 1'b0;
      latch_timer <= '0;
    end else if (step) begin
      hold_byte   <= hold_byte_next;
      hold_full   <= hold_full_next;
      hold_last   <= hold_last_next;
      shift_byte  <= shift_byte_next;
      bit_index   <= bit_index_next;
      bit_timer   <= bit_timer_next;
      active      <= active_next;
      cur_last    <= cur_last_next;
      latch_timer <= latch_timer_next;
    end
  end

endmodule

// File: test/rgb_led_serial_encoder_test.sv
// Testbench for rgb_led_serial_encoder: drives line ticks, predicts every result and checks it.
// Covers reset timing, extreme timing registers, an unused register index and random frames.
// Depends on rlse_pkg and the rgb_led_serial_encoder RTL.
`timescale 1ns / 100ps

module rgb_led_serial_encoder_test;

  localparam int STALL_LIMIT = 1000;
  localparam logic [rlse_pkg::CFG_INDEX_WIDTH-1:0] REG_NONE = 8'hFF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  rlse_pkg::item_t in_data;
  logic out_valid;
  logic out_ready;
  rlse_pkg::result_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [rlse_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [rlse_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

  // Line state of the encoder as the testbench sees it.
  rlse_pkg::cfg_t timing;
  logic [7:0] held_byte = 8'd0;
  logic held_full = 1'b0;
  logic held_last = 1'b0;
  logic [7:0] shifter = 8'd0;
  logic [2:0] bit_count = 3'd0;
  logic [7:0] bit_ticks = 8'd0;
  logic busy = 1'b0;
  logic frame_closing = 1'b0;
  logic [15:0] latch_left = 16'd0;

  rlse_pkg::result_t line_due[$];

  int gap_max = 19;
  int stall_max = 19;
  int errors = 0;
  int ticks_sent = 0;
  int bytes_taken = 0;
  int frames_closed = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  rgb_led_serial_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no request, result or register write for %0d cycles.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic void load_shifter();
    shifter = held_byte;
    frame_closing = held_last;
    held_full = 1'b0;
    bit_count = 3'd0;
    bit_ticks = 8'd0;
    busy = 1'b1;
  endfunction

  function automatic rlse_pkg::result_t predict_line_tick(input rlse_pkg::item_t tick);
    rlse_pkg::result_t res;
    logic full_before;
    logic [7:0] high_ticks;
    logic [8:0] next_ticks;
    full_before = held_full;
    res = '0;
    res.byte_taken = tick.byte_valid && !full_before;
    if (busy) begin
      high_ticks = shifter[7] ? timing.one_high_cycles : timing.zero_high_cycles;
      next_ticks = {1'b0, bit_ticks} + 9'd1;
      res.dout = bit_ticks < high_ticks;
      res.sending = 1'b1;
      if (next_ticks >= {1'b0, timing.period_cycles} || next_ticks[8]) begin
        bit_ticks = 8'd0;
        shifter = shifter << 1;
        bit_count = bit_count + 3'd1;
        if (bit_count == 3'd0) begin
          if (frame_closing) begin
            busy = 1'b0;
            latch_left = timing.latch_cycles;
          end else if (full_before) begin
            load_shifter();
          end else begin
            busy = 1'b0;
          end
        end
      end else begin
        bit_ticks = next_ticks[7:0];
      end
    end else if (latch_left != 16'd0) begin
      res.in_latch = 1'b1;
      latch_left = latch_left - 16'd1;
    end else if (full_before) begin
      load_shifter();
    end
    if (res.byte_taken) begin
      held_byte = tick.byte_value;
      held_last = tick.frame_end;
      held_full = 1'b1;
    end
    return res;
  endfunction

  task automatic send_tick(input logic valid, input logic [7:0] value, input logic last,
                           output logic taken);
    int gap;
    rlse_pkg::item_t tick;
    rlse_pkg::result_t want;
    gap = $urandom_range(0, gap_max);
    tick.byte_valid = valid;
    tick.byte_value = value;
    tick.frame_end = last;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_line_tick(tick);
    line_due.push_back(want);
    taken = want.byte_taken;
    ticks_sent++;
    if (taken) begin
      bytes_taken++;
      if (last) begin
        frames_closed++;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] value, input logic last);
    logic taken;
    taken = 1'b0;
    while (!taken) send_tick(1'b1, value, last, taken);
  endtask

  task automatic idle_ticks(input int count);
    logic taken;
    logic [7:0] noise;
    for (int k = 0; k < count; k++) begin
      noise = 8'($urandom);
      send_tick(1'b0, noise, noise[0], taken);
    end
  endtask

  task automatic settle_line();
    while (busy || latch_left != 16'd0 || held_full) idle_ticks(1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rlse_pkg::CFG_INDEX_WIDTH-1:0] index,
                           input logic [rlse_pkg::CFG_DATA_WIDTH-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      rlse_pkg::REG_PERIOD: begin
        timing.period_cycles = data[7:0];
      end
      rlse_pkg::REG_ZERO_HIGH: begin
        timing.zero_high_cycles = data[7:0];
      end
      rlse_pkg::REG_ONE_HIGH: begin
        timing.one_high_cycles = data[7:0];
      end
      rlse_pkg::REG_LATCH: begin
        timing.latch_cycles = data;
      end
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_timing();
    push_byte(8'hA5, 1'b0);
    settle_line();
  endtask

  task automatic test_fast_bits();
    write_reg(rlse_pkg::REG_PERIOD, 16'd0);
    write_reg(rlse_pkg::REG_ZERO_HIGH, 16'd0);
    write_reg(rlse_pkg::REG_ONE_HIGH, 16'd255);
    write_reg(rlse_pkg::REG_LATCH, 16'd0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h7E, 1'b1);
    push_byte(8'hFF, 1'b1);
    settle_line();
    write_reg(rlse_pkg::REG_PERIOD, 16'd1);
    push_byte(8'h69, 1'b1);
    settle_line();
    write_reg(rlse_pkg::REG_PERIOD, 16'd2);
    write_reg(rlse_pkg::REG_ZERO_HIGH, 16'd1);
    write_reg(rlse_pkg::REG_ONE_HIGH, 16'd2);
    write_reg(rlse_pkg::REG_LATCH, 16'd1);
    push_byte(8'h5A, 1'b1);
    push_byte(8'hC3, 1'b1);
    settle_line();
  endtask

  task automatic test_unused_register();
    write_reg(REG_NONE, 16'hFFFF);
    push_byte(8'h96, 1'b1);
    settle_line();
  endtask

  task automatic test_slow_bits();
    gap_max = 0;
    stall_max = 0;
    write_reg(rlse_pkg::REG_PERIOD, 16'd16);
    write_reg(rlse_pkg::REG_ZERO_HIGH, 16'd255);
    write_reg(rlse_pkg::REG_ONE_HIGH, 16'd15);
    write_reg(rlse_pkg::REG_LATCH, 16'd24);
    push_byte(8'h3C, 1'b1);
    settle_line();
    gap_max = 19;
    stall_max = 19;
  endtask

  task automatic test_random_frames();
    int first_tick;
    int frame_len;
    int roll;
    logic [15:0] word;
    for (int phase = 0; phase < 6; phase++) begin
      gap_max = (phase % 2 == 0) ? 19 : 0;
      stall_max = (phase % 3 == 1) ? 0 : 19;
      word = 16'($urandom);
      word[7:0] = 8'($urandom_range(0, 6));
      write_reg(rlse_pkg::REG_PERIOD, word);
      word = 16'($urandom);
      word[7:0] = 8'($urandom_range(0, 7));
      write_reg(rlse_pkg::REG_ZERO_HIGH, word);
      word = 16'($urandom);
      word[7:0] = 8'($urandom_range(0, 7));
      write_reg(rlse_pkg::REG_ONE_HIGH, word);
      write_reg(rlse_pkg::REG_LATCH, 16'($urandom_range(0, 16)));
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < 50) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          frame_len = $urandom_range(1, 4);
          for (int k = 0; k < frame_len; k++) begin
            push_byte(8'($urandom), k == frame_len - 1);
            if ($urandom_range(0, 7) == 0) begin
              idle_ticks($urandom_range(1, 12));
            end
          end
        end else if (roll < 9) begin
          idle_ticks($urandom_range(1, 10));
        end else begin
          push_byte(8'($urandom), 1'b0);
        end
      end
    end
    settle_line();
    gap_max = 19;
    stall_max = 19;
  endtask

  initial begin : result_checker
    int stall;
    rlse_pkg::result_t want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_checked++;
      if (line_due.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request waiting", results_checked));
      end else begin
        want = line_due.pop_front();
        if (out_data.dout !== want.dout) begin
          flag_error($sformatf("result %0d: dout %b, expected %b",
                               results_checked, out_data.dout, want.dout));
        end
        if (out_data.byte_taken !== want.byte_taken) begin
          flag_error($sformatf("result %0d: byte_taken %b, expected %b",
                               results_checked, out_data.byte_taken, want.byte_taken));
        end
        if (out_data.sending !== want.sending) begin
          flag_error($sformatf("result %0d: sending %b, expected %b",
                               results_checked, out_data.sending, want.sending));
        end
        if (out_data.in_latch !== want.in_latch) begin
          flag_error($sformatf("result %0d: in_latch %b, expected %b",
                               results_checked, out_data.in_latch, want.in_latch));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    timing.period_cycles = rlse_pkg::PERIOD_RESET;
    timing.zero_high_cycles = rlse_pkg::ZERO_HIGH_RESET;
    timing.one_high_cycles = rlse_pkg::ONE_HIGH_RESET;
    timing.latch_cycles = rlse_pkg::LATCH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_fast_bits();
    test_unused_register();
    test_slow_bits();
    test_random_frames();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d line ticks with %0d bytes taken in %0d closed frames,",
             ticks_sent, bytes_taken, frames_closed);
    $display("made %0d register writes, checked %0d results and found %0d errors.",
             reg_writes, results_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
